[hw/rtl/udp_test_packet_builder_assert.svh]
// ----------------------------------------------------------------------------
// udp_test_packet_builder_assert.svh
// Assertion macros used by the packet builder checker utpb_chk.
// ----------------------------------------------------------------------------
`ifndef UDP_TEST_PACKET_BUILDER_ASSERT_SVH
`define UDP_TEST_PACKET_BUILDER_ASSERT_SVH

// checked outside reset
`define UTPB_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("udp_test_packet_builder: assertion failed");

// checked on every edge, reset included
`define UTPB_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("udp_test_packet_builder: assertion failed");

`endif

[hw/rtl/utpb_pkg.sv]
// ----------------------------------------------------------------------------
// utpb_pkg
// Types and constants of the UDP test packet builder.
// ----------------------------------------------------------------------------
package utpb_pkg;

   localparam int MAX_QUEUES       = 32;
   localparam int MAX_PACKET_BYTES = 512;

   localparam int FRAME_BYTES_W = 10;
   localparam int CSR_DATA_W    = 48;
   localparam int CSR_INDEX_W   = 3;
   localparam int HDR_WORDS     = 5;
   localparam int HDR_INDEX_W   = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEST_MAC    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_MAC  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEST_IPV4   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_IPV4 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_BYTES = 3'd4;

   localparam logic [47:0] DEF_DEST_MAC    = 48'hFFFF_FFFF_FFFF;
   localparam logic [47:0] DEF_SOURCE_MAC  = 48'h0;
   localparam logic [31:0] DEF_DEST_IPV4   = 32'h0A10_0A01;
   localparam logic [31:0] DEF_SOURCE_IPV4 = 32'h0A10_0A02;
   localparam logic [FRAME_BYTES_W-1:0] DEF_FRAME_BYTES = 10'd60;
   localparam logic [FRAME_BYTES_W-1:0] MIN_FRAME_BYTES = 10'd42;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  IP_VER_IHL     = 8'h45;
   localparam logic [7:0]  IP_TOS         = 8'h10;
   localparam logic [7:0]  IP_TTL         = 8'd16;
   localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
   localparam logic [15:0] UDP_PORT_BASE  = 16'd60000;
   localparam logic [FRAME_BYTES_W-1:0] ETH_HDR_BYTES = 10'd14;
   localparam logic [FRAME_BYTES_W-1:0] UDP_OFFSET    = 10'd34;

   typedef struct packed {
      logic [4:0]  queue_index;
      logic [15:0] udp_source_port;
   } req_word_type;

   typedef struct packed {
      logic [63:0] frame_word;
      logic [3:0]  valid_bytes;
      logic        last_word;
   } rsp_word_type;

   typedef struct packed {
      logic [47:0]              dest_mac;
      logic [47:0]              source_mac;
      logic [31:0]              dest_ipv4;
      logic [31:0]              source_ipv4;
      logic [FRAME_BYTES_W-1:0] frame_bytes;
   } cfg_type;

   // header words, word 0 first on the wire
   typedef struct packed {
      logic [0:HDR_WORDS-1][63:0] words;
      logic [FRAME_BYTES_W-1:0]   frame_bytes;
   } hdr_type;

endpackage

[hw/rtl/utpb_csr.sv]
// ----------------------------------------------------------------------------
// utpb_csr
// Configuration registers with frame length clamping.
// ----------------------------------------------------------------------------
module utpb_csr #(
   parameter int MAX_PACKET_BYTES = utpb_pkg::MAX_PACKET_BYTES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [utpb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [utpb_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output utpb_pkg::cfg_type                   cfg
);
   import utpb_pkg::*;

   cfg_type                  cfg_ff;
   cfg_type                  cfg_in;
   logic [FRAME_BYTES_W-1:0] len_wr;
   logic [FRAME_BYTES_W-1:0] len_max;

   assign len_max = FRAME_BYTES_W'(MAX_PACKET_BYTES);

   always_comb begin
      len_wr = csr_wdata[FRAME_BYTES_W-1:0];
      if (len_wr < MIN_FRAME_BYTES) begin
         len_wr = MIN_FRAME_BYTES;
      end else if (len_wr > len_max) begin
         len_wr = len_max;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_DEST_MAC:    cfg_in.dest_mac    = csr_wdata;
            CSR_SOURCE_MAC:  cfg_in.source_mac  = csr_wdata;
            CSR_DEST_IPV4:   cfg_in.dest_ipv4   = csr_wdata[31:0];
            CSR_SOURCE_IPV4: cfg_in.source_ipv4 = csr_wdata[31:0];
            CSR_FRAME_BYTES: cfg_in.frame_bytes = len_wr;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest_mac    <= DEF_DEST_MAC;
         cfg_ff.source_mac  <= DEF_SOURCE_MAC;
         cfg_ff.dest_ipv4   <= DEF_DEST_IPV4;
         cfg_ff.source_ipv4 <= DEF_SOURCE_IPV4;
         cfg_ff.frame_bytes <= DEF_FRAME_BYTES;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hw/rtl/utpb_hdr.sv]
// ----------------------------------------------------------------------------
// utpb_hdr
// Request register and header builder with IPv4 checksum.
// ----------------------------------------------------------------------------
module utpb_hdr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  utpb_pkg::req_word_type req_word,
   input  utpb_pkg::cfg_type      cfg,
   output logic                   hdr_valid,
   input  logic                   hdr_take,
   output utpb_pkg::hdr_type      hdr
);
   import utpb_pkg::*;

   logic         req_valid_ff;
   logic         req_valid_in;
   req_word_type req_ff;

   logic [FRAME_BYTES_W-1:0] len;
   logic [15:0]              ip_len;
   logic [15:0]              udp_len;
   logic [6:0]               queue;
   logic [15:0]              dport;
   logic [18:0]              sum;
   logic [16:0]              fold1;
   logic [15:0]              fold2;
   logic [15:0]              csum;

   assign req_ready    = !req_valid_ff || hdr_take;
   assign req_valid_in = req_ready ? req_valid : req_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_word;
      end
   end

   assign len     = cfg.frame_bytes;
   assign ip_len  = 16'(len - ETH_HDR_BYTES);
   assign udp_len = 16'(len - UDP_OFFSET);

   always_comb begin
      queue = {2'b00, req_ff.queue_index};
      if (queue >= 7'(MAX_QUEUES)) begin
         queue = 7'(MAX_QUEUES - 1);
      end
   end

   assign dport = UDP_PORT_BASE + 16'(queue);

   // IPv4 header checksum over the constant and variable header words
   assign sum = 19'({IP_VER_IHL, IP_TOS}) + 19'({IP_TTL, IP_PROTO_UDP})
              + 19'(ip_len)
              + 19'(cfg.source_ipv4[31:16]) + 19'(cfg.source_ipv4[15:0])
              + 19'(cfg.dest_ipv4[31:16])   + 19'(cfg.dest_ipv4[15:0]);
   assign fold1 = 17'(sum[15:0]) + 17'(sum[18:16]);
   assign fold2 = fold1[15:0] + 16'(fold1[16]);
   assign csum  = ~fold2;

   assign hdr.words = {cfg.dest_mac, cfg.source_mac, ETHERTYPE_IPV4,
                       IP_VER_IHL, IP_TOS, ip_len, 16'h0000, 16'h0000,
                       IP_TTL, IP_PROTO_UDP, csum, cfg.source_ipv4, cfg.dest_ipv4,
                       req_ff.udp_source_port, dport, udp_len};
   assign hdr.frame_bytes = len;
   assign hdr_valid       = req_valid_ff;

endmodule

[hw/rtl/utpb_emit.sv]
// ----------------------------------------------------------------------------
// utpb_emit
// Held-header word sequencer: one 64-bit word per cycle while rsp_ready.
// ----------------------------------------------------------------------------
module utpb_emit #(
   parameter int MAX_PACKET_BYTES = utpb_pkg::MAX_PACKET_BYTES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   hdr_valid,
   output logic                   hdr_take,
   input  utpb_pkg::hdr_type      hdr,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output utpb_pkg::rsp_word_type rsp_word
);
   import utpb_pkg::*;

   localparam int WCNT_W = $clog2((MAX_PACKET_BYTES + 7) / 8);

   logic                       busy_ff,  busy_in;
   logic [WCNT_W-1:0]          cnt_ff,   cnt_in;
   logic [WCNT_W-1:0]          last_ff,  last_in;
   logic [2:0]                 tail_ff;
   logic [0:HDR_WORDS-1][63:0] words_ff;
   logic                       is_last;
   logic                       advance;
   logic [FRAME_BYTES_W:0]     nwords;

   assign is_last  = (cnt_ff == last_ff);
   assign advance  = busy_ff && rsp_ready;
   assign hdr_take = hdr_valid && (!busy_ff || (advance && is_last));
   assign nwords   = ({1'b0, hdr.frame_bytes} + (FRAME_BYTES_W + 1)'(7)) >> 3;
   assign last_in  = WCNT_W'(nwords - (FRAME_BYTES_W + 1)'(1));

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (hdr_take) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (advance) begin
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + WCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hdr_take) begin
         words_ff <= hdr.words;
         last_ff  <= last_in;
         tail_ff  <= hdr.frame_bytes[2:0];
      end
   end

   always_comb begin
      rsp_word.frame_word = 64'h0;
      if (cnt_ff < WCNT_W'(HDR_WORDS)) begin
         rsp_word.frame_word = words_ff[cnt_ff[HDR_INDEX_W-1:0]];
      end
      rsp_word.valid_bytes = 4'd8;
      if (is_last && (tail_ff != 3'd0)) begin
         rsp_word.valid_bytes = {1'b0, tail_ff};
      end
      rsp_word.last_word = is_last;
   end

   assign rsp_valid = busy_ff;

endmodule

[hw/rtl/udp_test_packet_builder.sv]
// ----------------------------------------------------------------------------
// udp_test_packet_builder
// Builds one Ethernet/IPv4/UDP test frame per request word and streams it as
// big-endian 64-bit words.
// ----------------------------------------------------------------------------
// A request is registered, its 40 header bytes and IPv4 checksum are formed
// from it, and the frame then leaves at one word per cycle while rsp_ready is
// high, ceil(frame_bytes / 8) words (6 to 64); the single output word path
// sets the rate. The next request's header waits ready, and its first word
// follows the previous frame's last word with no idle cycle. The request
// register feeds the emitter's registers. frame_bytes is clamped on write to
// 42..MAX_PACKET_BYTES; payload bytes are zero.
// ----------------------------------------------------------------------------
module udp_test_packet_builder #(
   parameter int MAX_PACKET_BYTES = utpb_pkg::MAX_PACKET_BYTES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  utpb_pkg::req_word_type           req_word,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output utpb_pkg::rsp_word_type           rsp_word,
   input  logic                             csr_write,
   input  logic [utpb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [utpb_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import utpb_pkg::*;

   cfg_type cfg;
   hdr_type hdr;
   logic    hdr_valid;
   logic    hdr_take;

   utpb_csr #(
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   utpb_hdr u_hdr (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .cfg       (cfg),
      .hdr_valid (hdr_valid),
      .hdr_take  (hdr_take),
      .hdr       (hdr)
   );

   utpb_emit #(
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
   ) u_emit (
      .clock     (clock),
      .reset     (reset),
      .hdr_valid (hdr_valid),
      .hdr_take  (hdr_take),
      .hdr       (hdr),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

[hw/rtl/utpb_chk.sv]
// ----------------------------------------------------------------------------
// utpb_chk
// Port-level checks of the packet builder, bound to the top level.
// ----------------------------------------------------------------------------
`include "udp_test_packet_builder_assert.svh"

module utpb_chk (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input utpb_pkg::rsp_word_type rsp_word
);
   import utpb_pkg::*;

   `UTPB_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid)

   `UTPB_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))

   `UTPB_ASSERT(a_full_inner, clock, reset,
      rsp_valid && !rsp_word.last_word |-> rsp_word.valid_bytes == 4'd8)

   `UTPB_ASSERT(a_bytes_range, clock, reset,
      rsp_valid |-> rsp_word.valid_bytes != 4'd0 && rsp_word.valid_bytes <= 4'd8)

   `UTPB_ASSERT(a_no_gap, clock, reset,
      rsp_valid && rsp_ready && !rsp_word.last_word |=> rsp_valid)

endmodule

bind udp_test_packet_builder utpb_chk u_chk (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);
